// ===== rtl/core/scch_pkg.sv =====
// Shared types, protocol codes and the microcode program of the serial camera capture host.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package scch_pkg;

  localparam int SIZE_W   = 24;
  localparam int POS_W    = 10;
  localparam int PKG_W    = 10;
  localparam int DIV_W    = 9;
  localparam int CNT_W    = $clog2(SIZE_W + 1);
  localparam int STEP_W   = 7;
  localparam int FRAME_LEN = 6;
  localparam int FIDX_W   = 3;

  localparam logic [PKG_W-1:0] MIN_PACKAGE_BYTES = 10'd8;
  localparam logic [PKG_W-1:0] MAX_PACKAGE_BYTES = 10'd512;
  localparam logic [PKG_W-1:0] PKG_OVERHEAD      = 10'd6;

  // register indexes
  localparam logic [2:0] REG_COLOUR_TYPE     = 3'd0;
  localparam logic [2:0] REG_RAW_RESOLUTION  = 3'd1;
  localparam logic [2:0] REG_JPEG_RESOLUTION = 3'd2;
  localparam logic [2:0] REG_PACKAGE_BYTES   = 3'd3;
  localparam logic [2:0] REG_SNAPSHOT_TYPE   = 3'd4;
  localparam logic [2:0] REG_PICTURE_TYPE    = 3'd5;

  // operations
  localparam logic [1:0] OP_CONNECT = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_RX_BYTE = 2'd2;
  localparam logic [1:0] OP_RETRY   = 2'd3;

  // result kinds
  localparam logic [2:0] K_TX   = 3'd0;
  localparam logic [2:0] K_IMG  = 3'd1;
  localparam logic [2:0] K_DONE = 3'd2;
  localparam logic [2:0] K_FAIL = 3'd3;
  localparam logic [2:0] K_CONN = 3'd4;

  // phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_SYNC_ACK  = 4'd1;
  localparam logic [3:0] PH_SYNC_SYNC = 4'd2;
  localparam logic [3:0] PH_READY     = 4'd3;
  localparam logic [3:0] PH_W_INIT    = 4'd4;
  localparam logic [3:0] PH_W_PKG     = 4'd5;
  localparam logic [3:0] PH_W_SNAP    = 4'd6;
  localparam logic [3:0] PH_W_GET     = 4'd7;
  localparam logic [3:0] PH_W_DATA    = 4'd8;
  localparam logic [3:0] PH_W_PACKAGE = 4'd9;

  // protocol bytes
  localparam logic [7:0] B_HEAD       = 8'hAA;
  localparam logic [7:0] CMD_SYNC     = 8'h0D;
  localparam logic [7:0] CMD_ACK      = 8'h0E;
  localparam logic [7:0] CMD_INITIAL  = 8'h01;
  localparam logic [7:0] CMD_PKG_SIZE = 8'h06;
  localparam logic [7:0] CMD_SNAPSHOT = 8'h05;
  localparam logic [7:0] CMD_GET_PIC  = 8'h04;
  localparam logic [7:0] CMD_DATA     = 8'h0A;
  localparam logic [7:0] B_END        = 8'hF0;
  localparam logic [7:0] B_SET_PKG    = 8'h08;
  localparam logic [7:0] B_ZERO       = 8'h00;

  // jump types
  localparam logic [2:0] JT_NEXT   = 3'd0;
  localparam logic [2:0] JT_GOTO   = 3'd1;
  localparam logic [2:0] JT_IF     = 3'd2;
  localparam logic [2:0] JT_IFNOT  = 3'd3;
  localparam logic [2:0] JT_ACCEPT = 3'd4;
  localparam logic [2:0] JT_FRAME  = 3'd5;

  // jump conditions
  localparam logic [3:0] CND_ACK      = 4'd0;
  localparam logic [3:0] CND_SYNC     = 4'd1;
  localparam logic [3:0] CND_DATA     = 4'd2;
  localparam logic [3:0] CND_FEND     = 4'd3;
  localparam logic [3:0] CND_WIN      = 4'd4;
  localparam logic [3:0] CND_PEND     = 4'd5;
  localparam logic [3:0] CND_IDX_GE   = 4'd6;
  localparam logic [3:0] CND_TOT_ZERO = 4'd7;
  localparam logic [3:0] CND_BUSY     = 4'd8;

  // value sources
  localparam logic [3:0] VS_CONST  = 4'd0;
  localparam logic [3:0] VS_RX     = 4'd1;
  localparam logic [3:0] VS_COLOUR = 4'd2;
  localparam logic [3:0] VS_RAW    = 4'd3;
  localparam logic [3:0] VS_JPEG   = 4'd4;
  localparam logic [3:0] VS_SNAP   = 4'd5;
  localparam logic [3:0] VS_PIC    = 4'd6;
  localparam logic [3:0] VS_P_LO   = 4'd7;
  localparam logic [3:0] VS_P_HI   = 4'd8;
  localparam logic [3:0] VS_IDX_LO = 4'd9;
  localparam logic [3:0] VS_IDX_HI = 4'd10;

  // last-flag sources
  localparam logic [1:0] LS_NO       = 2'd0;
  localparam logic [1:0] LS_YES      = 2'd1;
  localparam logic [1:0] LS_NOT_PEND = 2'd2;

  // position, index and total operations
  localparam logic [1:0] POS_KEEP  = 2'd0;
  localparam logic [1:0] POS_ZERO  = 2'd1;
  localparam logic [1:0] POS_INC   = 2'd2;
  localparam logic [1:0] POS_STORE = 2'd3;
  localparam logic [1:0] IDX_KEEP  = 2'd0;
  localparam logic [1:0] IDX_ZERO  = 2'd1;
  localparam logic [1:0] IDX_INC   = 2'd2;
  localparam logic [1:0] TOT_KEEP  = 2'd0;
  localparam logic [1:0] TOT_CLEAR = 2'd1;
  localparam logic [1:0] TOT_LOAD  = 2'd2;

  // program entry points
  localparam logic [STEP_W-1:0] A_DISPATCH  = 7'd0;
  localparam logic [STEP_W-1:0] A_CONNECT   = 7'd1;
  localparam logic [STEP_W-1:0] A_CAPTURE   = 7'd2;
  localparam logic [STEP_W-1:0] A_RETRY     = 7'd8;
  localparam logic [STEP_W-1:0] A_FRAMEBYTE = 7'd14;
  localparam logic [STEP_W-1:0] A_FD_SA     = 7'd16;
  localparam logic [STEP_W-1:0] A_FD_SS     = 7'd18;
  localparam logic [STEP_W-1:0] A_FD_INIT   = 7'd27;
  localparam logic [STEP_W-1:0] A_FD_PKG    = 7'd34;
  localparam logic [STEP_W-1:0] A_FD_SNAP   = 7'd41;
  localparam logic [STEP_W-1:0] A_FD_GET    = 7'd48;
  localparam logic [STEP_W-1:0] A_FD_DATA   = 7'd50;
  localparam logic [STEP_W-1:0] A_PKGBYTE   = 7'd56;
  localparam logic [STEP_W-1:0] A_REQ       = 7'd61;
  localparam logic [STEP_W-1:0] A_FINAL     = 7'd67;
  localparam logic [STEP_W-1:0] A_FAIL      = 7'd74;

  typedef struct packed {
    logic [2:0]        jt;
    logic [3:0]        cond;
    logic [STEP_W-1:0] target;
    logic              emit;
    logic [2:0]        kind;
    logic [3:0]        vsel;
    logic [7:0]        cbyte;
    logic [1:0]        lsel;
    logic              ph_we;
    logic [3:0]        ph_val;
    logic [1:0]        pos_op;
    logic [1:0]        idx_op;
    logic [1:0]        tot_op;
    logic              frame_clr;
    logic              div_start;
  } uword_t;

  typedef struct packed {
    uword_t w;
    logic   go;
    logic   take;
  } seq_ctl_t;

  typedef struct packed {
    logic       ack;
    logic       sync_ok;
    logic       data_ok;
    logic       fend;
    logic       win;
    logic       pend;
    logic       idx_ge;
    logic       tot_zero;
    logic       busy;
    logic       pos_zero;
    logic       out_room;
    logic [3:0] phase;
  } dp_flags_t;

  typedef struct packed {
    logic [7:0]       colour;
    logic [7:0]       raw;
    logic [7:0]       jpeg;
    logic [7:0]       snap;
    logic [7:0]       pic;
    logic [PKG_W-1:0] pkg;
  } cfg_t;

  function automatic uword_t uw_send(input logic [3:0] vsel, input logic [7:0] cb,
                                     input logic lst);
    uword_t w;
    w = '0;
    w.emit  = 1'b1;
    w.kind  = K_TX;
    w.vsel  = vsel;
    w.cbyte = cb;
    if (lst) begin
      w.lsel   = LS_YES;
      w.jt     = JT_GOTO;
      w.target = A_DISPATCH;
    end else begin
      w.lsel = LS_NO;
      w.jt   = JT_NEXT;
    end
    return w;
  endfunction

  function automatic uword_t uw_jump(input logic [2:0] jt, input logic [3:0] cond,
                                     input logic [STEP_W-1:0] target);
    uword_t w;
    w = '0;
    w.jt     = jt;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] a);
    uword_t w;
    w = uw_jump(JT_GOTO, CND_ACK, A_DISPATCH);
    unique case (a)
      A_DISPATCH: w.jt = JT_ACCEPT;
      A_CONNECT: begin
        w.ph_we     = 1'b1;
        w.ph_val    = PH_SYNC_ACK;
        w.pos_op    = POS_ZERO;
        w.idx_op    = IDX_ZERO;
        w.tot_op    = TOT_CLEAR;
        w.frame_clr = 1'b1;
      end
      A_CAPTURE: begin
        w        = uw_send(VS_CONST, B_HEAD, 1'b0);
        w.pos_op = POS_ZERO;
        w.ph_we  = 1'b1;
        w.ph_val = PH_W_INIT;
      end
      A_CAPTURE + 7'd1: w = uw_send(VS_CONST, CMD_INITIAL, 1'b0);
      A_CAPTURE + 7'd2: w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_CAPTURE + 7'd3: w = uw_send(VS_COLOUR, B_ZERO, 1'b0);
      A_CAPTURE + 7'd4: w = uw_send(VS_RAW, B_ZERO, 1'b0);
      A_CAPTURE + 7'd5: w = uw_send(VS_JPEG, B_ZERO, 1'b1);
      A_RETRY:          w = uw_send(VS_CONST, B_HEAD, 1'b0);
      A_RETRY + 7'd1:   w = uw_send(VS_CONST, CMD_SYNC, 1'b0);
      A_RETRY + 7'd2:   w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_RETRY + 7'd3:   w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_RETRY + 7'd4:   w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_RETRY + 7'd5:   w = uw_send(VS_CONST, B_ZERO, 1'b1);
      A_FRAMEBYTE: begin
        w        = uw_jump(JT_IFNOT, CND_FEND, A_DISPATCH);
        w.pos_op = POS_STORE;
      end
      A_FRAMEBYTE + 7'd1: w = uw_jump(JT_FRAME, CND_ACK, A_DISPATCH);
      A_FD_SA: begin
        w       = uw_jump(JT_IFNOT, CND_ACK, A_DISPATCH);
        w.cbyte = CMD_SYNC;
      end
      A_FD_SA + 7'd1: begin
        w.ph_we  = 1'b1;
        w.ph_val = PH_SYNC_SYNC;
      end
      A_FD_SS:         w = uw_jump(JT_IFNOT, CND_SYNC, A_FD_SS + 7'd8);
      A_FD_SS + 7'd1:  w = uw_send(VS_CONST, B_HEAD, 1'b0);
      A_FD_SS + 7'd2:  w = uw_send(VS_CONST, CMD_ACK, 1'b0);
      A_FD_SS + 7'd3:  w = uw_send(VS_CONST, CMD_SYNC, 1'b0);
      A_FD_SS + 7'd4:  w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_SS + 7'd5:  w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_SS + 7'd6:  w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_SS + 7'd7: begin
        w        = uw_send(VS_CONST, B_ZERO, 1'b1);
        w.kind   = K_CONN;
        w.ph_we  = 1'b1;
        w.ph_val = PH_READY;
      end
      A_FD_SS + 7'd8: begin
        w.ph_we  = 1'b1;
        w.ph_val = PH_SYNC_ACK;
      end
      A_FD_INIT: begin
        w       = uw_jump(JT_IFNOT, CND_ACK, A_FAIL);
        w.cbyte = CMD_INITIAL;
      end
      A_FD_INIT + 7'd1: begin
        w        = uw_send(VS_CONST, B_HEAD, 1'b0);
        w.ph_we  = 1'b1;
        w.ph_val = PH_W_PKG;
      end
      A_FD_INIT + 7'd2: w = uw_send(VS_CONST, CMD_PKG_SIZE, 1'b0);
      A_FD_INIT + 7'd3: w = uw_send(VS_CONST, B_SET_PKG, 1'b0);
      A_FD_INIT + 7'd4: w = uw_send(VS_P_LO, B_ZERO, 1'b0);
      A_FD_INIT + 7'd5: w = uw_send(VS_P_HI, B_ZERO, 1'b0);
      A_FD_INIT + 7'd6: w = uw_send(VS_CONST, B_ZERO, 1'b1);
      A_FD_PKG: begin
        w       = uw_jump(JT_IFNOT, CND_ACK, A_FAIL);
        w.cbyte = CMD_PKG_SIZE;
      end
      A_FD_PKG + 7'd1: begin
        w        = uw_send(VS_CONST, B_HEAD, 1'b0);
        w.ph_we  = 1'b1;
        w.ph_val = PH_W_SNAP;
      end
      A_FD_PKG + 7'd2: w = uw_send(VS_CONST, CMD_SNAPSHOT, 1'b0);
      A_FD_PKG + 7'd3: w = uw_send(VS_SNAP, B_ZERO, 1'b0);
      A_FD_PKG + 7'd4: w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_PKG + 7'd5: w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_PKG + 7'd6: w = uw_send(VS_CONST, B_ZERO, 1'b1);
      A_FD_SNAP: begin
        w       = uw_jump(JT_IFNOT, CND_ACK, A_FAIL);
        w.cbyte = CMD_SNAPSHOT;
      end
      A_FD_SNAP + 7'd1: begin
        w        = uw_send(VS_CONST, B_HEAD, 1'b0);
        w.ph_we  = 1'b1;
        w.ph_val = PH_W_GET;
      end
      A_FD_SNAP + 7'd2: w = uw_send(VS_CONST, CMD_GET_PIC, 1'b0);
      A_FD_SNAP + 7'd3: w = uw_send(VS_PIC, B_ZERO, 1'b0);
      A_FD_SNAP + 7'd4: w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_SNAP + 7'd5: w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FD_SNAP + 7'd6: w = uw_send(VS_CONST, B_ZERO, 1'b1);
      A_FD_GET: begin
        w       = uw_jump(JT_IFNOT, CND_ACK, A_FAIL);
        w.cbyte = CMD_GET_PIC;
      end
      A_FD_GET + 7'd1: begin
        w.ph_we  = 1'b1;
        w.ph_val = PH_W_DATA;
      end
      A_FD_DATA: w = uw_jump(JT_IFNOT, CND_DATA, A_FAIL);
      A_FD_DATA + 7'd1: begin
        w           = uw_jump(JT_NEXT, CND_ACK, A_DISPATCH);
        w.div_start = 1'b1;
        w.idx_op    = IDX_ZERO;
      end
      A_FD_DATA + 7'd2: w = uw_jump(JT_IF, CND_BUSY, A_FD_DATA + 7'd2);
      A_FD_DATA + 7'd3: begin
        w        = uw_jump(JT_NEXT, CND_ACK, A_DISPATCH);
        w.tot_op = TOT_LOAD;
      end
      A_FD_DATA + 7'd4: w = uw_jump(JT_IF, CND_TOT_ZERO, A_FINAL);
      A_FD_DATA + 7'd5: begin
        w        = uw_jump(JT_GOTO, CND_ACK, A_REQ);
        w.ph_we  = 1'b1;
        w.ph_val = PH_W_PACKAGE;
      end
      A_PKGBYTE: w = uw_jump(JT_IFNOT, CND_WIN, A_PKGBYTE + 7'd2);
      A_PKGBYTE + 7'd1: begin
        w      = uw_send(VS_RX, B_ZERO, 1'b0);
        w.kind = K_IMG;
        w.lsel = LS_NOT_PEND;
      end
      A_PKGBYTE + 7'd2: begin
        w        = uw_jump(JT_IFNOT, CND_PEND, A_DISPATCH);
        w.pos_op = POS_INC;
      end
      A_PKGBYTE + 7'd3: begin
        w        = uw_jump(JT_NEXT, CND_ACK, A_DISPATCH);
        w.idx_op = IDX_INC;
      end
      A_PKGBYTE + 7'd4: w = uw_jump(JT_IF, CND_IDX_GE, A_FINAL);
      A_REQ: begin
        w        = uw_send(VS_CONST, B_HEAD, 1'b0);
        w.pos_op = POS_ZERO;
      end
      A_REQ + 7'd1:   w = uw_send(VS_CONST, CMD_ACK, 1'b0);
      A_REQ + 7'd2:   w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_REQ + 7'd3:   w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_REQ + 7'd4:   w = uw_send(VS_IDX_LO, B_ZERO, 1'b0);
      A_REQ + 7'd5:   w = uw_send(VS_IDX_HI, B_ZERO, 1'b1);
      A_FINAL:        w = uw_send(VS_CONST, B_HEAD, 1'b0);
      A_FINAL + 7'd1: w = uw_send(VS_CONST, CMD_ACK, 1'b0);
      A_FINAL + 7'd2: w = uw_send(VS_CONST, CMD_DATA, 1'b0);
      A_FINAL + 7'd3: w = uw_send(VS_CONST, B_ZERO, 1'b0);
      A_FINAL + 7'd4: w = uw_send(VS_CONST, B_END, 1'b0);
      A_FINAL + 7'd5: w = uw_send(VS_CONST, B_END, 1'b0);
      A_FINAL + 7'd6: begin
        w        = uw_send(VS_CONST, B_ZERO, 1'b1);
        w.kind   = K_DONE;
        w.ph_we  = 1'b1;
        w.ph_val = PH_READY;
      end
      A_FAIL: begin
        w        = uw_send(VS_CONST, B_ZERO, 1'b1);
        w.kind   = K_FAIL;
        w.ph_we  = 1'b1;
        w.ph_val = PH_READY;
      end
      default: w = uw_jump(JT_GOTO, CND_ACK, A_DISPATCH);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/scch_divider.sv =====
// Iterative restoring divider: image size over package payload length, one bit a cycle.
// Depends on scch_pkg.
`timescale 1ns / 1ps

module scch_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [scch_pkg::SIZE_W-1:0] dividend,
  input  logic [scch_pkg::DIV_W-1:0]  divisor,
  output logic                        busy,
  output logic [scch_pkg::SIZE_W-1:0] quotient
);
  import scch_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [SIZE_W-1:0] quo;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [DIV_W-1:0]  rem_next;

  assign trial    = {rem, quo[SIZE_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign diff     = trial - {1'b0, dsr};
  assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  assign busy     = cnt != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(SIZE_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[SIZE_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/scch_datapath.sv =====
// Datapath of the capture host: phase, frame buffer, counters, result register.
// Driven by the control word of scch_sequencer; depends on scch_pkg and scch_divider.
`timescale 1ns / 1ps

module scch_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  scch_pkg::seq_ctl_t   ctl,
  input  scch_pkg::cfg_t       cfg,
  input  logic [7:0]           rx_byte,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           kind,
  output logic [7:0]           value,
  output logic                 last,
  output scch_pkg::dp_flags_t  flags
);
  import scch_pkg::*;

  logic [3:0]               phase;
  logic [FRAME_LEN-1:0][7:0] frame;
  logic [POS_W-1:0]         pos;
  logic [SIZE_W-1:0]        idx;
  logic [SIZE_W-1:0]        total;
  logic [7:0]               rx_hold;
  logic [FIDX_W-1:0]        fpos;
  logic [POS_W-1:0]         pos_inc;
  logic [7:0]               value_next;
  logic                     last_next;
  logic                     div_busy;
  logic [SIZE_W-1:0]        div_q;
  logic [PKG_W-1:0]         divisor_full;
  uword_t                   w;

  assign w            = ctl.w;
  assign fpos         = (pos < POS_W'(FRAME_LEN)) ? pos[FIDX_W-1:0] : '0;
  assign pos_inc      = pos + POS_W'(1);
  assign divisor_full = cfg.pkg - PKG_OVERHEAD;

  scch_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.go & w.div_start),
    .dividend ({frame[5], frame[4], frame[3]}),
    .divisor  (divisor_full[DIV_W-1:0]),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    flags.ack      = frame[0] == B_HEAD && frame[1] == CMD_ACK && frame[2] == w.cbyte &&
                     frame[4] == B_ZERO && frame[5] == B_ZERO;
    flags.sync_ok  = frame[0] == B_HEAD && frame[1] == CMD_SYNC && frame[2] == B_ZERO &&
                     frame[3] == B_ZERO && frame[4] == B_ZERO && frame[5] == B_ZERO;
    flags.data_ok  = frame[0] == B_HEAD && frame[1] == CMD_DATA;
    flags.fend     = fpos == FIDX_W'(FRAME_LEN - 1);
    flags.win      = pos > POS_W'(3) && pos < (cfg.pkg - PKG_W'(2));
    flags.pend     = pos_inc >= cfg.pkg;
    flags.idx_ge   = idx >= total;
    flags.tot_zero = total == '0;
    flags.busy     = div_busy;
    flags.pos_zero = pos == '0;
    flags.out_room = !out_valid || out_ready;
    flags.phase    = phase;
  end

  always_comb begin
    case (w.vsel)
      VS_RX:     value_next = rx_hold;
      VS_COLOUR: value_next = cfg.colour;
      VS_RAW:    value_next = cfg.raw;
      VS_JPEG:   value_next = cfg.jpeg;
      VS_SNAP:   value_next = cfg.snap;
      VS_PIC:    value_next = cfg.pic;
      VS_P_LO:   value_next = cfg.pkg[7:0];
      VS_P_HI:   value_next = {6'b0, cfg.pkg[PKG_W-1:8]};
      VS_IDX_LO: value_next = idx[7:0];
      VS_IDX_HI: value_next = idx[15:8];
      default:   value_next = w.cbyte;
    endcase
    case (w.lsel)
      LS_YES:      last_next = 1'b1;
      LS_NOT_PEND: last_next = !flags.pend;
      default:     last_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_IDLE;
      pos       <= '0;
      idx       <= '0;
      total     <= '0;
      frame     <= '0;
    end else begin
      if (ctl.go && w.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.go) begin
        if (w.ph_we) begin
          phase <= w.ph_val;
        end
        if (w.frame_clr) begin
          frame <= '0;
        end
        case (w.pos_op)
          POS_ZERO: pos <= '0;
          POS_INC:  pos <= pos_inc;
          POS_STORE: begin
            frame[fpos] <= rx_hold;
            pos         <= flags.fend ? '0 : POS_W'(fpos) + POS_W'(1);
          end
          default: ;
        endcase
        case (w.idx_op)
          IDX_ZERO: idx <= '0;
          IDX_INC:  idx <= idx + SIZE_W'(1);
          default: ;
        endcase
        case (w.tot_op)
          TOT_CLEAR: total <= '0;
          TOT_LOAD:  total <= div_q;
          default: ;
        endcase
      end
    end
  end

  // hold the beat payloads
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rx_hold <= rx_byte;
    end
    if (ctl.go && w.emit) begin
      kind  <= w.kind;
      value <= value_next;
      last  <= last_next;
    end
  end

endmodule

// ===== rtl/core/scch_sequencer.sv =====
// Microcode sequencer: step counter, program ROM lookup, condition and dispatch jumps.
// Depends on scch_pkg.
`timescale 1ns / 1ps

module scch_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          operation,
  input  scch_pkg::dp_flags_t flags,
  output logic                in_ready,
  output scch_pkg::seq_ctl_t  ctl
);
  import scch_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [STEP_W-1:0] step_inc;
  uword_t            w;
  logic              cond_true;
  logic              go;

  function automatic logic [STEP_W-1:0] entry_for(input logic [1:0] op,
                                                  input logic [3:0] ph,
                                                  input logic pz);
    logic [STEP_W-1:0] e;
    e = A_DISPATCH;
    unique case (op)
      OP_CONNECT: e = A_CONNECT;
      OP_CAPTURE: if (ph == PH_READY) e = A_CAPTURE;
      OP_RETRY:   if (ph == PH_SYNC_ACK && pz) e = A_RETRY;
      OP_RX_BYTE: begin
        unique case (ph) inside
          PH_W_PACKAGE: e = A_PKGBYTE;
          PH_SYNC_ACK, PH_SYNC_SYNC, PH_W_INIT, PH_W_PKG, PH_W_SNAP, PH_W_GET,
          PH_W_DATA: e = A_FRAMEBYTE;
          default: e = A_DISPATCH;
        endcase
      end
    endcase
    return e;
  endfunction

  function automatic logic [STEP_W-1:0] frame_entry(input logic [3:0] ph);
    logic [STEP_W-1:0] e;
    unique case (ph)
      PH_SYNC_ACK:  e = A_FD_SA;
      PH_SYNC_SYNC: e = A_FD_SS;
      PH_W_INIT:    e = A_FD_INIT;
      PH_W_PKG:     e = A_FD_PKG;
      PH_W_SNAP:    e = A_FD_SNAP;
      PH_W_GET:     e = A_FD_GET;
      PH_W_DATA:    e = A_FD_DATA;
      default:      e = A_DISPATCH;
    endcase
    return e;
  endfunction

  assign w        = ucode(step);
  assign step_inc = step + STEP_W'(1);
  assign in_ready = w.jt == JT_ACCEPT;
  assign go       = in_ready ? in_valid : (!w.emit || flags.out_room);
  assign ctl.w    = w;
  assign ctl.go   = go;
  assign ctl.take = in_ready && in_valid;

  always_comb begin
    case (w.cond)
      CND_ACK:      cond_true = flags.ack;
      CND_SYNC:     cond_true = flags.sync_ok;
      CND_DATA:     cond_true = flags.data_ok;
      CND_FEND:     cond_true = flags.fend;
      CND_WIN:      cond_true = flags.win;
      CND_PEND:     cond_true = flags.pend;
      CND_IDX_GE:   cond_true = flags.idx_ge;
      CND_TOT_ZERO: cond_true = flags.tot_zero;
      CND_BUSY:     cond_true = flags.busy;
      default:      cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (w.jt)
      JT_GOTO:   step_next = w.target;
      JT_IF:     step_next = cond_true ? w.target : step_inc;
      JT_IFNOT:  step_next = cond_true ? step_inc : w.target;
      JT_ACCEPT: step_next = entry_for(operation, flags.phase, flags.pos_zero);
      JT_FRAME:  step_next = frame_entry(flags.phase);
      default:   step_next = step_inc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= A_DISPATCH;
    end else if (go) begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/serial_camera_capture_host.sv =====
// Top level of the serial camera capture host: configuration registers and the
// sequencer and datapath. Depends on scch_pkg, scch_sequencer and scch_datapath.
`timescale 1ns / 1ps

// An input beat is taken whenever the sequencer sits at its dispatch step. The item
// then runs one microcode step per cycle, and each result beat takes one step, which
// stalls while the output register is full. The DATA frame waits for the package
// count, which comes from a one-bit-per-cycle divider.
// Configuration writes take effect on the next clock edge.
module serial_camera_capture_host (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       last
);
  import scch_pkg::*;

  logic [7:0]       colour_type;
  logic [7:0]       raw_resolution;
  logic [7:0]       jpeg_resolution;
  logic [PKG_W-1:0] package_bytes;
  logic [7:0]       snapshot_type;
  logic [7:0]       picture_type;
  logic [PKG_W-1:0] pkg_eff;
  cfg_t             cfg;
  seq_ctl_t         ctl;
  dp_flags_t        flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_type     <= 8'd7;
      raw_resolution  <= 8'd7;
      jpeg_resolution <= 8'd7;
      package_bytes   <= 10'd64;
      snapshot_type   <= 8'd0;
      picture_type    <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLOUR_TYPE:     colour_type     <= cfg_data[7:0];
        REG_RAW_RESOLUTION:  raw_resolution  <= cfg_data[7:0];
        REG_JPEG_RESOLUTION: jpeg_resolution <= cfg_data[7:0];
        REG_PACKAGE_BYTES:   package_bytes   <= cfg_data;
        REG_SNAPSHOT_TYPE:   snapshot_type   <= cfg_data[7:0];
        REG_PICTURE_TYPE:    picture_type    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // clamp the package size to the supported range
  assign pkg_eff = (package_bytes < MIN_PACKAGE_BYTES) ? MIN_PACKAGE_BYTES :
                   (package_bytes > MAX_PACKAGE_BYTES) ? MAX_PACKAGE_BYTES : package_bytes;

  assign cfg.colour = colour_type;
  assign cfg.raw    = raw_resolution;
  assign cfg.jpeg   = jpeg_resolution;
  assign cfg.snap   = snapshot_type;
  assign cfg.pic    = picture_type;
  assign cfg.pkg    = pkg_eff;

  scch_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .flags     (flags),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  scch_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .rx_byte   (rx_byte),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .kind      (kind),
    .value     (value),
    .last      (last),
    .flags     (flags)
  );

endmodule
